// File: rtl/scs_pkg.sv
// Package with item types, opcode constants and register indexes for the syscall scanner.
package scs_pkg;

	localparam int unsigned MAX_FOUND_DEF = 256;
	localparam int unsigned WIN_CELLS     = 11;
	localparam int unsigned ADDR_W        = 47;
	localparam int unsigned SIZE_W        = 32;
	localparam int unsigned OFFSET_W      = 32;
	localparam int unsigned DET_ADDR_W    = 48;
	localparam int unsigned DET_NUM_W     = 9;

	localparam logic [7:0] OP_ESC     = 8'h0F;
	localparam logic [7:0] OP_SYSCALL = 8'h05;
	localparam logic [7:0] OP_SYSENTR = 8'h34;
	localparam logic [7:0] OP_CALL    = 8'hE8;
	localparam logic [7:0] OP_JMP     = 8'hE9;
	localparam logic [7:0] OP_GRP5    = 8'hFF;
	localparam logic [7:0] MRM_CALLI  = 8'h15;
	localparam logic [7:0] MRM_JMPI   = 8'h25;
	localparam logic [7:0] MRM_MASK   = 8'hC7;
	localparam logic [7:0] MRM_RIP    = 8'h05;
	localparam logic [7:0] OP_MOV_LO  = 8'hB8;
	localparam logic [7:0] OP_MOV_HI  = 8'hBF;
	localparam logic [7:0] OP_VEX2    = 8'hC5;
	localparam logic [7:0] OP_VEX3    = 8'hC4;
	localparam logic [7:0] HI_MASK    = 8'hF0;
	localparam logic [7:0] HI_JCC     = 8'h80;
	localparam logic [7:0] HI_REX     = 8'h40;

	typedef enum logic [1:0] {
		CFG_AREA_BASE     = 2'd0,
		CFG_EXCLUDED_BASE = 2'd1,
		CFG_EXCLUDED_SIZE = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       region_first;
		logic       region_last;
		logic       scan_start;
	} in_item_t;

	typedef struct packed {
		logic [DET_ADDR_W-1:0] detection_address;
		logic [DET_NUM_W-1:0]  detection_number;
	} out_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
	} cell_t;

	typedef struct packed {
		logic pair;
		logic embedded;
	} verdict_t;

endpackage

// File: rtl/scs_cell.sv
// One window cell: holds a byte and its in-region flag and passes them on each item.
module scs_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          clear,
	input  scs_pkg::cell_t prev,
	output scs_pkg::cell_t cur
);

	scs_pkg::cell_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (shift) begin
			cell_q.data  <= prev.data;
			cell_q.valid <= prev.valid & ~clear;
		end
	end

	assign cur = cell_q;

endmodule

// File: rtl/scs_judge.sv
// Pair detection and embedded-instruction heuristics over the window cells.
module scs_judge (
	input  logic              [7:0] code_byte,
	input  scs_pkg::cell_t          win [scs_pkg::WIN_CELLS],
	output scs_pkg::verdict_t       verdict
);

	function automatic logic rip_opcode(input logic [7:0] op);
		logic r;
		case (op)
			8'h8D, 8'h8B, 8'h89, 8'h3B, 8'h39, 8'h03,
			8'h01, 8'h33, 8'h31, 8'h2B, 8'h29: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic alu_imm_opcode(input logic [7:0] op);
		logic r;
		case (op)
			8'h05, 8'h0D, 8'h15, 8'h1D, 8'h25, 8'h2D, 8'h35, 8'h3D: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	logic emb;

	always_comb begin
		emb = 1'b0;
		for (int m = 2; m <= 5; m++) begin
			if (win[m].valid && win[m].data == scs_pkg::OP_ESC &&
			    (win[m-1].data & scs_pkg::HI_MASK) == scs_pkg::HI_JCC) begin
				emb = 1'b1;
			end
		end
		for (int m = 1; m <= 4; m++) begin
			if (win[m].valid &&
			    (win[m].data == scs_pkg::OP_CALL || win[m].data == scs_pkg::OP_JMP)) begin
				emb = 1'b1;
			end
		end
		for (int m = 2; m <= 6; m++) begin
			if (win[m].valid && win[m].data == scs_pkg::OP_GRP5 &&
			    (win[m-1].data == scs_pkg::MRM_CALLI ||
			     win[m-1].data == scs_pkg::MRM_JMPI)) begin
				emb = 1'b1;
			end
		end
		for (int m = 1; m <= 4; m++) begin
			if (win[m+2].valid &&
			    (win[m+1].data & scs_pkg::MRM_MASK) == scs_pkg::MRM_RIP) begin
				if (rip_opcode(win[m+2].data)) begin
					emb = 1'b1;
				end
				if (win[m+3].valid &&
				    (win[m+3].data & scs_pkg::HI_MASK) == scs_pkg::HI_REX) begin
					emb = 1'b1;
				end
			end
		end
		for (int m = 1; m <= 4; m++) begin
			if (win[m].valid && win[m].data >= scs_pkg::OP_MOV_LO &&
			    win[m].data <= scs_pkg::OP_MOV_HI) begin
				emb = 1'b1;
			end
			if (win[m].valid && alu_imm_opcode(win[m].data)) begin
				emb = 1'b1;
			end
		end
		for (int m = 2; m <= 10; m++) begin
			if (win[m].valid &&
			    (win[m].data == scs_pkg::OP_VEX3 || win[m].data == scs_pkg::OP_VEX2)) begin
				emb = 1'b1;
			end
		end
	end

	assign verdict.pair = win[0].valid && win[0].data == scs_pkg::OP_ESC &&
	                      (code_byte == scs_pkg::OP_SYSCALL ||
	                       code_byte == scs_pkg::OP_SYSENTR);
	assign verdict.embedded = emb;

endmodule

// File: rtl/syscall_opcode_filter_scanner.sv
// Top level of the syscall opcode scanner: window cell chain, offset, count and output register.
//
//  channel   direction  handshake               payload
//  byte      in         byte_valid/byte_stall   byte_item (scs_pkg::in_item_t)
//  found     out        found_valid/found_stall found_item (scs_pkg::out_item_t)
//  cfg       in         cfg_we                  cfg_index, cfg_data
//
// One byte is taken per cycle unless stalled; a hit is registered as its closing byte is taken.
// The eleven-cell chain shifts once per item and the heuristics decode within that cycle.
// Reset clears the window, offset, count, registers and the output valid flag.
// While a detection waits under found_stall, byte_stall is high and no byte is taken.
module syscall_opcode_filter_scanner #(
	parameter int unsigned MAX_FOUND = scs_pkg::MAX_FOUND_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  scs_pkg::in_item_t           byte_item,
	output logic                        found_valid,
	input  logic                        found_stall,
	output scs_pkg::out_item_t          found_item,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [scs_pkg::ADDR_W-1:0]  cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_FOUND + 1);

	logic [scs_pkg::ADDR_W-1:0]   area_base_q;
	logic [scs_pkg::ADDR_W-1:0]   excluded_base_q;
	logic [scs_pkg::SIZE_W-1:0]   excluded_size_q;
	logic [scs_pkg::OFFSET_W-1:0] offset_q;
	logic [CNT_W-1:0]             count_q;
	logic                         found_valid_q;
	scs_pkg::out_item_t           found_item_q;

	scs_pkg::cell_t    cells [scs_pkg::WIN_CELLS];
	scs_pkg::cell_t    view  [scs_pkg::WIN_CELLS];
	scs_pkg::cell_t    head;
	scs_pkg::verdict_t verdict;

	logic                         accept;
	logic [scs_pkg::OFFSET_W-1:0] offset_cur;
	logic [scs_pkg::OFFSET_W-1:0] offset_next;
	logic [scs_pkg::OFFSET_W-1:0] pair_pos;
	logic [CNT_W-1:0]             count_cur;
	logic [CNT_W-1:0]             count_next;
	logic                         excluded;
	logic                         hit;

	assign accept     = byte_valid && !byte_stall;
	assign byte_stall = found_valid_q && found_stall;

	assign head.data  = byte_item.code_byte;
	assign head.valid = 1'b1;

	for (genvar k = 0; k < scs_pkg::WIN_CELLS; k++) begin : g_chain
		if (k == 0) begin : g_first
			scs_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (accept),
				.clear  (1'b0),
				.prev   (head),
				.cur    (cells[k])
			);
		end else begin : g_rest
			scs_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (accept),
				.clear  (byte_item.region_first),
				.prev   (cells[k-1]),
				.cur    (cells[k])
			);
		end
		assign view[k].data  = cells[k].data;
		assign view[k].valid = cells[k].valid & ~byte_item.region_first;
	end

	scs_judge u_judge (
		.code_byte (byte_item.code_byte),
		.win       (view),
		.verdict   (verdict)
	);

	assign offset_cur  = byte_item.region_first ? '0 : offset_q;
	assign offset_next = (&offset_cur) ? offset_cur : offset_cur + 1'b1;
	assign pair_pos    = offset_cur - 1'b1;
	assign count_cur   = byte_item.scan_start ? '0 : count_q;

	assign excluded = ({1'b0, area_base_q} >= {1'b0, excluded_base_q}) &&
	                  ({1'b0, area_base_q} <
	                   ({1'b0, excluded_base_q} +
	                    {{(scs_pkg::ADDR_W + 1 - scs_pkg::SIZE_W){1'b0}}, excluded_size_q}));

	assign hit        = verdict.pair && !verdict.embedded && !excluded &&
	                    (count_cur < CNT_W'(MAX_FOUND));
	assign count_next = count_cur + CNT_W'(hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_base_q     <= '0;
			excluded_base_q <= '0;
			excluded_size_q <= '0;
		end else if (cfg_we) begin
			case (scs_pkg::cfg_index_t'(cfg_index))
				scs_pkg::CFG_AREA_BASE:     area_base_q     <= cfg_data;
				scs_pkg::CFG_EXCLUDED_BASE: excluded_base_q <= cfg_data;
				scs_pkg::CFG_EXCLUDED_SIZE: excluded_size_q <= cfg_data[scs_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q      <= '0;
			count_q       <= '0;
			found_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				offset_q      <= offset_next;
				count_q       <= count_next;
				found_valid_q <= hit;
			end else if (!found_stall) begin
				found_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			found_item_q.detection_address <=
				{1'b0, area_base_q} +
				{{(scs_pkg::DET_ADDR_W - scs_pkg::OFFSET_W){1'b0}}, pair_pos};
			found_item_q.detection_number <= scs_pkg::DET_NUM_W'(count_next);
		end
	end

	assign found_valid = found_valid_q;
	assign found_item  = found_item_q;

endmodule
